// ----- sv/a64rel_pkg.sv -----
// Shared types and constants for the AArch64 relocation patcher.
package a64rel_pkg;

  localparam int OP_W   = 12;
  localparam int ADDR_W = 64;
  localparam int WORD_W = 32;

  // write width codes
  localparam logic [1:0] WW_NONE = 2'd0;
  localparam logic [1:0] WW_16   = 2'd1;
  localparam logic [1:0] WW_32   = 2'd2;
  localparam logic [1:0] WW_64   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  localparam logic [ADDR_W-1:0] PAGE_MASK = 64'hffff_ffff_ffff_f000;

  typedef enum logic [1:0] {
    KIND_ABS,
    KIND_PREL,
    KIND_PAGE
  } kind_t;

  typedef enum logic [1:0] {
    FMT_NONE,
    FMT_DATA,
    FMT_MOVW,
    FMT_IMM
  } fmt_t;

  typedef enum logic [2:0] {
    ENC_26,
    ENC_19,
    ENC_14,
    ENC_12,
    ENC_ADR
  } enc_t;

  // decoded control for one relocation
  typedef struct packed {
    kind_t      kind;
    fmt_t       fmt;
    enc_t       enc;
    logic [5:0] lsb;
    logic [4:0] flen;
    logic       sgn;
    logic       check;
    logic [5:0] zb;
    logic [5:0] ob;
    logic       ones_ok;
    logic [1:0] width;
    logic [1:0] status;
  } dec_t;

endpackage

// ----- sv/a64rel_in_if.sv -----
// Relocation request channel: valid/ready with the relocation fields.
interface a64rel_in_if;
  import a64rel_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        place_addr;
  logic [ADDR_W-1:0]        symbol_value;
  logic signed [ADDR_W-1:0] addend;
  logic [WORD_W-1:0]        old_word;

  modport source (
    output valid, op, place_addr, symbol_value, addend, old_word,
    input  ready
  );

  modport sink (
    input  valid, op, place_addr, symbol_value, addend, old_word,
    output ready
  );
endinterface

// ----- sv/a64rel_out_if.sv -----
// Patch result channel: valid/ready with the patched word, width and status.
interface a64rel_out_if;
  import a64rel_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] new_word;
  logic [1:0]        write_width;
  logic [1:0]        status;

  modport source (
    output valid, new_word, write_width, status,
    input  ready
  );

  modport sink (
    input  valid, new_word, write_width, status,
    output ready
  );
endinterface

// ----- sv/a64rel_decode.sv -----
// Relocation type decoder: maps the ELF type number to datapath controls.
module a64rel_decode (
  input  logic [a64rel_pkg::OP_W-1:0] op,
  output a64rel_pkg::dec_t            dec
);
  import a64rel_pkg::*;

  localparam logic [OP_W-1:0] R_NONE           = 12'd0;
  localparam logic [OP_W-1:0] R_NONE_ALT       = 12'd256;
  localparam logic [OP_W-1:0] R_ABS64          = 12'd257;
  localparam logic [OP_W-1:0] R_ABS32          = 12'd258;
  localparam logic [OP_W-1:0] R_ABS16          = 12'd259;
  localparam logic [OP_W-1:0] R_PREL64         = 12'd260;
  localparam logic [OP_W-1:0] R_PREL32         = 12'd261;
  localparam logic [OP_W-1:0] R_PREL16         = 12'd262;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G0   = 12'd263;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G0NC = 12'd264;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G1   = 12'd265;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G1NC = 12'd266;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G2   = 12'd267;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G2NC = 12'd268;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G3   = 12'd269;
  localparam logic [OP_W-1:0] R_MOVW_SABS_G0   = 12'd270;
  localparam logic [OP_W-1:0] R_MOVW_SABS_G1   = 12'd271;
  localparam logic [OP_W-1:0] R_MOVW_SABS_G2   = 12'd272;
  localparam logic [OP_W-1:0] R_LD_PREL_LO19   = 12'd273;
  localparam logic [OP_W-1:0] R_ADR_PREL_LO21  = 12'd274;
  localparam logic [OP_W-1:0] R_ADR_PG_HI21    = 12'd275;
  localparam logic [OP_W-1:0] R_ADR_PG_HI21NC  = 12'd276;
  localparam logic [OP_W-1:0] R_ADD_LO12NC     = 12'd277;
  localparam logic [OP_W-1:0] R_LDST8_LO12NC   = 12'd278;
  localparam logic [OP_W-1:0] R_TSTBR14        = 12'd279;
  localparam logic [OP_W-1:0] R_CONDBR19       = 12'd280;
  localparam logic [OP_W-1:0] R_JUMP26         = 12'd282;
  localparam logic [OP_W-1:0] R_CALL26         = 12'd283;
  localparam logic [OP_W-1:0] R_LDST16_LO12NC  = 12'd284;
  localparam logic [OP_W-1:0] R_LDST32_LO12NC  = 12'd285;
  localparam logic [OP_W-1:0] R_LDST64_LO12NC  = 12'd286;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G0   = 12'd287;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G0NC = 12'd288;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G1   = 12'd289;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G1NC = 12'd290;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G2   = 12'd291;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G2NC = 12'd292;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G3   = 12'd293;
  localparam logic [OP_W-1:0] R_LDST128_LO12NC = 12'd299;
  localparam logic [OP_W-1:0] R_ADR_GOT_PAGE   = 12'd311;

  function automatic dec_t base_d(input logic [1:0] st);
    dec_t d;
    d         = '0;
    d.kind    = KIND_ABS;
    d.fmt     = FMT_NONE;
    d.enc     = ENC_26;
    d.width   = WW_NONE;
    d.status  = st;
    return d;
  endfunction

  function automatic dec_t data_d(input kind_t k, input logic [1:0] ww, input logic chk);
    dec_t d;
    d         = base_d(ST_OK);
    d.kind    = k;
    d.fmt     = FMT_DATA;
    d.width   = ww;
    d.check   = chk;
    d.zb      = (ww == WW_16) ? 6'd16 : 6'd32;
    d.ob      = (ww == WW_16) ? 6'd15 : 6'd31;
    d.ones_ok = 1'b1;
    return d;
  endfunction

  function automatic dec_t movw_d(input kind_t k, input logic [5:0] lsb, input logic sgn,
                                  input logic chk);
    dec_t d;
    d         = base_d(ST_OK);
    d.kind    = k;
    d.fmt     = FMT_MOVW;
    d.width   = WW_32;
    d.lsb     = lsb;
    d.sgn     = sgn;
    d.check   = chk;
    d.zb      = 6'd16;
    d.ob      = 6'd16;
    d.ones_ok = sgn;
    return d;
  endfunction

  function automatic dec_t imm_d(input kind_t k, input logic [5:0] lsb, input logic [4:0] len,
                                 input enc_t enc, input logic chk);
    dec_t d;
    d         = base_d(ST_OK);
    d.kind    = k;
    d.fmt     = FMT_IMM;
    d.enc     = enc;
    d.width   = WW_32;
    d.lsb     = lsb;
    d.flen    = len;
    d.check   = chk;
    d.zb      = {1'b0, len} - 6'd1;
    d.ob      = {1'b0, len} - 6'd1;
    d.ones_ok = 1'b1;
    return d;
  endfunction

  always_comb begin
    case (op)
      R_NONE, R_NONE_ALT: dec = base_d(ST_OK);
      R_ABS64:          dec = data_d(KIND_ABS, WW_64, 1'b0);
      R_ABS32:          dec = data_d(KIND_ABS, WW_32, 1'b1);
      R_ABS16:          dec = data_d(KIND_ABS, WW_16, 1'b1);
      R_PREL64:         dec = data_d(KIND_PREL, WW_64, 1'b0);
      R_PREL32:         dec = data_d(KIND_PREL, WW_32, 1'b1);
      R_PREL16:         dec = data_d(KIND_PREL, WW_16, 1'b1);
      R_MOVW_UABS_G0:   dec = movw_d(KIND_ABS, 6'd0, 1'b0, 1'b1);
      R_MOVW_UABS_G0NC: dec = movw_d(KIND_ABS, 6'd0, 1'b0, 1'b0);
      R_MOVW_UABS_G1:   dec = movw_d(KIND_ABS, 6'd16, 1'b0, 1'b1);
      R_MOVW_UABS_G1NC: dec = movw_d(KIND_ABS, 6'd16, 1'b0, 1'b0);
      R_MOVW_UABS_G2:   dec = movw_d(KIND_ABS, 6'd32, 1'b0, 1'b1);
      R_MOVW_UABS_G2NC: dec = movw_d(KIND_ABS, 6'd32, 1'b0, 1'b0);
      R_MOVW_UABS_G3:   dec = movw_d(KIND_ABS, 6'd48, 1'b0, 1'b0);
      R_MOVW_SABS_G0:   dec = movw_d(KIND_ABS, 6'd0, 1'b1, 1'b1);
      R_MOVW_SABS_G1:   dec = movw_d(KIND_ABS, 6'd16, 1'b1, 1'b1);
      R_MOVW_SABS_G2:   dec = movw_d(KIND_ABS, 6'd32, 1'b1, 1'b1);
      R_MOVW_PREL_G0:   dec = movw_d(KIND_PREL, 6'd0, 1'b1, 1'b1);
      R_MOVW_PREL_G0NC: dec = movw_d(KIND_PREL, 6'd0, 1'b0, 1'b0);
      R_MOVW_PREL_G1:   dec = movw_d(KIND_PREL, 6'd16, 1'b1, 1'b1);
      R_MOVW_PREL_G1NC: dec = movw_d(KIND_PREL, 6'd16, 1'b0, 1'b0);
      R_MOVW_PREL_G2:   dec = movw_d(KIND_PREL, 6'd32, 1'b1, 1'b1);
      R_MOVW_PREL_G2NC: dec = movw_d(KIND_PREL, 6'd32, 1'b0, 1'b0);
      R_MOVW_PREL_G3:   dec = movw_d(KIND_PREL, 6'd48, 1'b1, 1'b0);
      R_LD_PREL_LO19, R_CONDBR19:
        dec = imm_d(KIND_PREL, 6'd2, 5'd19, ENC_19, 1'b1);
      R_ADR_PREL_LO21:  dec = imm_d(KIND_PREL, 6'd0, 5'd21, ENC_ADR, 1'b1);
      R_ADR_PG_HI21:    dec = imm_d(KIND_PAGE, 6'd12, 5'd21, ENC_ADR, 1'b1);
      R_ADR_PG_HI21NC, R_ADR_GOT_PAGE:
        dec = imm_d(KIND_PAGE, 6'd12, 5'd21, ENC_ADR, 1'b0);
      R_ADD_LO12NC, R_LDST8_LO12NC:
        dec = imm_d(KIND_ABS, 6'd0, 5'd12, ENC_12, 1'b0);
      R_LDST16_LO12NC:  dec = imm_d(KIND_ABS, 6'd1, 5'd11, ENC_12, 1'b0);
      R_LDST32_LO12NC:  dec = imm_d(KIND_ABS, 6'd2, 5'd10, ENC_12, 1'b0);
      R_LDST64_LO12NC:  dec = imm_d(KIND_ABS, 6'd3, 5'd9, ENC_12, 1'b0);
      R_LDST128_LO12NC: dec = imm_d(KIND_ABS, 6'd4, 5'd8, ENC_12, 1'b0);
      R_TSTBR14:        dec = imm_d(KIND_PREL, 6'd2, 5'd14, ENC_14, 1'b1);
      R_JUMP26, R_CALL26:
        dec = imm_d(KIND_PREL, 6'd2, 5'd26, ENC_26, 1'b1);
      default:          dec = base_d(ST_UNSUP);
    endcase
  end

endmodule

// ----- sv/a64rel_calc.sv -----
// Relocation datapath: value calculation, range check and field insertion.
module a64rel_calc (
  input  a64rel_pkg::dec_t                   dec,
  input  logic [a64rel_pkg::ADDR_W-1:0]      place_addr,
  input  logic [a64rel_pkg::ADDR_W-1:0]      symbol_value,
  input  logic signed [a64rel_pkg::ADDR_W-1:0] addend,
  input  logic [a64rel_pkg::WORD_W-1:0]      old_word,
  output logic [a64rel_pkg::ADDR_W-1:0]      new_word,
  output logic [1:0]                         write_width,
  output logic [1:0]                         status
);
  import a64rel_pkg::*;

  logic [ADDR_W-1:0] opc;
  logic [ADDR_W-1:0] csa_s;
  logic [ADDR_W-1:0] csa_c;
  logic [ADDR_W-1:0] sum;
  logic [ADDR_W-1:0] rval;
  logic [ADDR_W-1:0] sval;
  logic [ADDR_W-1:0] zmask;
  logic [ADDR_W-1:0] omask;
  logic [ADDR_W-1:0] fmask;
  logic [25:0]       field;
  logic [15:0]       imm16;
  logic              zero_fit;
  logic              ones_fit;
  logic              ovf;
  logic [WORD_W-1:0] w;

  // S + A - P folded into one carry-save step and a single 64-bit add;
  // the page form drops the low 12 bits afterwards (no borrow crosses them)
  always_comb begin
    case (dec.kind)
      KIND_PREL: opc = ~place_addr;
      KIND_PAGE: opc = ~(place_addr & PAGE_MASK);
      default:   opc = '0;
    endcase
  end

  assign csa_s = symbol_value ^ addend ^ opc;
  assign csa_c = ((symbol_value & addend) | (symbol_value & opc) | (addend & opc)) << 1;
  assign sum   = csa_s + csa_c + {{(ADDR_W-1){1'b0}}, (dec.kind != KIND_ABS)};
  assign rval  = (dec.kind == KIND_PAGE) ? (sum & PAGE_MASK) : sum;
  assign sval  = ADDR_W'($signed(rval) >>> dec.lsb);

  assign zmask    = {ADDR_W{1'b1}} << dec.zb;
  assign omask    = {ADDR_W{1'b1}} << dec.ob;
  assign zero_fit = (sval & zmask) == '0;
  assign ones_fit = dec.ones_ok && ((sval | ~omask) == {ADDR_W{1'b1}});
  assign ovf      = dec.check && !(zero_fit || ones_fit);

  assign fmask = ~({ADDR_W{1'b1}} << dec.flen);
  assign field = sval[25:0] & fmask[25:0];
  assign imm16 = (dec.sgn && sval[ADDR_W-1]) ? ~sval[15:0] : sval[15:0];

  always_comb begin
    w = old_word;
    case (dec.fmt)
      FMT_MOVW: begin
        if (dec.sgn) begin
          w[30:29] = sval[ADDR_W-1] ? 2'b00 : 2'b10;
        end
        w[20:5] = imm16;
      end
      FMT_IMM: begin
        case (dec.enc)
          ENC_26: w[25:0]  = field;
          ENC_19: w[23:5]  = field[18:0];
          ENC_14: w[18:5]  = field[13:0];
          ENC_12: w[21:10] = field[11:0];
          ENC_ADR: begin
            w[30:29] = field[1:0];
            w[23:5]  = field[20:2];
          end
          default: w = old_word;
        endcase
      end
      default: w = old_word;
    endcase
  end

  always_comb begin
    new_word    = '0;
    write_width = dec.width;
    status      = ovf ? ST_OVF : ST_OK;
    case (dec.fmt)
      FMT_DATA: begin
        case (dec.width)
          WW_16:   new_word = {48'd0, rval[15:0]};
          WW_32:   new_word = {32'd0, rval[31:0]};
          default: new_word = rval;
        endcase
      end
      FMT_MOVW, FMT_IMM: new_word = {32'd0, w};
      default: status = dec.status;
    endcase
  end

endmodule

// ----- sv/aarch64_relocation_patcher.sv -----
// AArch64 ELF RELA relocation patcher, top level.
// Applies one relocation per clock while the sink is ready: a request transfer is captured
// in an input register, the type decode, one 64-bit carry-save add, the range check and the
// immediate insertion run combinationally after it, and the patched word lands in the result
// register once the result stage can advance. Throughput is one relocation per clock with the
// sink ready; the critical path is the 64-bit adder followed by the arithmetic shift and the
// range mask compare between the two registers. Ready is held low only while both registers
// are full and the result is stalled. No state is kept between relocations.
module aarch64_relocation_patcher (
  input  logic         clk,
  input  logic         rst,
  a64rel_in_if.sink    reloc,
  a64rel_out_if.source patch
);
  import a64rel_pkg::*;

  logic                     s1_valid;
  logic [OP_W-1:0]          s1_op;
  logic [ADDR_W-1:0]        s1_place;
  logic [ADDR_W-1:0]        s1_symbol;
  logic signed [ADDR_W-1:0] s1_addend;
  logic [WORD_W-1:0]        s1_word;

  logic                     res_valid;
  logic [ADDR_W-1:0]        res_word;
  logic [1:0]               res_width;
  logic [1:0]               res_status;

  dec_t                     dec;
  logic [ADDR_W-1:0]        word_next;
  logic [1:0]               width_next;
  logic [1:0]               status_next;
  logic                     s1_adv;

  assign s1_adv      = !res_valid || patch.ready;
  assign reloc.ready = !s1_valid || s1_adv;

  a64rel_decode u_decode (
    .op  (s1_op),
    .dec (dec)
  );

  a64rel_calc u_calc (
    .dec          (dec),
    .place_addr   (s1_place),
    .symbol_value (s1_symbol),
    .addend       (s1_addend),
    .old_word     (s1_word),
    .new_word     (word_next),
    .write_width  (width_next),
    .status       (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (reloc.ready) begin
        s1_valid <= reloc.valid;
      end
      if (s1_adv) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reloc.valid && reloc.ready) begin
      s1_op     <= reloc.op;
      s1_place  <= reloc.place_addr;
      s1_symbol <= reloc.symbol_value;
      s1_addend <= reloc.addend;
      s1_word   <= reloc.old_word;
    end
    if (s1_valid && s1_adv) begin
      res_word   <= word_next;
      res_width  <= width_next;
      res_status <= status_next;
    end
  end

  assign patch.valid       = res_valid;
  assign patch.new_word    = res_word;
  assign patch.write_width = res_width;
  assign patch.status      = res_status;

  // a held relocation is not dropped while the result stage is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("relocation lost in input stage");

  a_unsup: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_UNSUP |-> res_width == WW_NONE && res_word == '0)
    else $error("unsupported type produced a write");

  a_w16: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_width == WW_16 |-> res_word[63:16] == '0)
    else $error("16-bit write has stray upper bits");

  a_w32: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_width == WW_32 |-> res_word[63:32] == '0)
    else $error("32-bit write has stray upper bits");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_OVF |-> res_width != WW_NONE && res_width != WW_64)
    else $error("overflow reported on an unchecked width");

endmodule

// ----- dv/tb_aarch64_relocation_patcher.sv -----
// Testbench for the AArch64 relocation patcher: directed table, then random relocations.
module tb_aarch64_relocation_patcher;
  import a64rel_pkg::*;

  // relocation type numbers
  localparam logic [OP_W-1:0] R_NULL                = 12'd0;
  localparam logic [OP_W-1:0] R_NONE                = 12'd256;
  localparam logic [OP_W-1:0] R_ABS64               = 12'd257;
  localparam logic [OP_W-1:0] R_ABS32               = 12'd258;
  localparam logic [OP_W-1:0] R_ABS16               = 12'd259;
  localparam logic [OP_W-1:0] R_PREL64              = 12'd260;
  localparam logic [OP_W-1:0] R_PREL32              = 12'd261;
  localparam logic [OP_W-1:0] R_PREL16              = 12'd262;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G0        = 12'd263;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G0_NC     = 12'd264;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G1        = 12'd265;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G1_NC     = 12'd266;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G2        = 12'd267;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G2_NC     = 12'd268;
  localparam logic [OP_W-1:0] R_MOVW_UABS_G3        = 12'd269;
  localparam logic [OP_W-1:0] R_MOVW_SABS_G0        = 12'd270;
  localparam logic [OP_W-1:0] R_MOVW_SABS_G1        = 12'd271;
  localparam logic [OP_W-1:0] R_MOVW_SABS_G2        = 12'd272;
  localparam logic [OP_W-1:0] R_LD_PREL_LO19        = 12'd273;
  localparam logic [OP_W-1:0] R_ADR_PREL_LO21       = 12'd274;
  localparam logic [OP_W-1:0] R_ADR_PREL_PG_HI21    = 12'd275;
  localparam logic [OP_W-1:0] R_ADR_PREL_PG_HI21_NC = 12'd276;
  localparam logic [OP_W-1:0] R_ADD_ABS_LO12_NC     = 12'd277;
  localparam logic [OP_W-1:0] R_LDST8_ABS_LO12_NC   = 12'd278;
  localparam logic [OP_W-1:0] R_TSTBR14             = 12'd279;
  localparam logic [OP_W-1:0] R_CONDBR19            = 12'd280;
  localparam logic [OP_W-1:0] R_JUMP26              = 12'd282;
  localparam logic [OP_W-1:0] R_CALL26              = 12'd283;
  localparam logic [OP_W-1:0] R_LDST16_ABS_LO12_NC  = 12'd284;
  localparam logic [OP_W-1:0] R_LDST32_ABS_LO12_NC  = 12'd285;
  localparam logic [OP_W-1:0] R_LDST64_ABS_LO12_NC  = 12'd286;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G0        = 12'd287;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G0_NC     = 12'd288;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G1        = 12'd289;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G1_NC     = 12'd290;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G2        = 12'd291;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G2_NC     = 12'd292;
  localparam logic [OP_W-1:0] R_MOVW_PREL_G3        = 12'd293;
  localparam logic [OP_W-1:0] R_LDST128_ABS_LO12_NC = 12'd299;
  localparam logic [OP_W-1:0] R_ADR_GOT_PAGE        = 12'd311;

  localparam int OP_N = 40;
  localparam logic [OP_W-1:0] OP_LIST [OP_N] = '{
    R_NULL, R_NONE, R_ABS64, R_ABS32, R_ABS16, R_PREL64, R_PREL32, R_PREL16,
    R_MOVW_UABS_G0, R_MOVW_UABS_G0_NC, R_MOVW_UABS_G1, R_MOVW_UABS_G1_NC,
    R_MOVW_UABS_G2, R_MOVW_UABS_G2_NC, R_MOVW_UABS_G3, R_MOVW_SABS_G0,
    R_MOVW_SABS_G1, R_MOVW_SABS_G2, R_LD_PREL_LO19, R_ADR_PREL_LO21,
    R_ADR_PREL_PG_HI21, R_ADR_PREL_PG_HI21_NC, R_ADD_ABS_LO12_NC,
    R_LDST8_ABS_LO12_NC, R_TSTBR14, R_CONDBR19, R_JUMP26, R_CALL26,
    R_LDST16_ABS_LO12_NC, R_LDST32_ABS_LO12_NC, R_LDST64_ABS_LO12_NC,
    R_MOVW_PREL_G0, R_MOVW_PREL_G0_NC, R_MOVW_PREL_G1, R_MOVW_PREL_G1_NC,
    R_MOVW_PREL_G2, R_MOVW_PREL_G2_NC, R_MOVW_PREL_G3, R_LDST128_ABS_LO12_NC,
    R_ADR_GOT_PAGE
  };

  localparam int RAND_ITEMS  = 1200;
  localparam int HOLD_CYCLES = 80;
  localparam int DIR_N       = 29;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        place;
    logic [ADDR_W-1:0]        sym;
    logic signed [ADDR_W-1:0] addend;
    logic [WORD_W-1:0]        old;
  } reloc_t;

  typedef struct packed {
    logic [ADDR_W-1:0] new_word;
    logic [1:0]        width;
    logic [1:0]        status;
  } patch_t;

  typedef struct packed {
    reloc_t rq;
    logic   typed;
    patch_t res;
  } dir_row_t;

  // typed rows carry their own expectation, the rest go through the predictor
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{'{R_NULL, ~64'd0, ~64'd0, ~64'd0, ~32'd0}, 1'b1, '{64'd0, WW_NONE, ST_OK}},
    '{'{R_NONE, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b1, '{64'd0, WW_NONE, ST_OK}},
    '{'{12'hfff, ~64'd0, ~64'd0, ~64'd0, ~32'd0}, 1'b1, '{64'd0, WW_NONE, ST_UNSUP}},
    '{'{12'd1, 64'd5, 64'd7, 64'd9, 32'd3}, 1'b1, '{64'd0, WW_NONE, ST_UNSUP}},
    '{'{12'd281, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b1, '{64'd0, WW_NONE, ST_UNSUP}},
    '{'{R_ABS64, 64'd0, ~64'd0, 64'd1, 32'd0}, 1'b1, '{64'd0, WW_64, ST_OK}},
    '{'{R_ABS64, ~64'd0, 64'h8000_0000_0000_0000, ~64'd0, ~32'd0}, 1'b1,
      '{64'h7fff_ffff_ffff_ffff, WW_64, ST_OK}},
    '{'{R_ABS32, 64'd0, 64'hffff_ffff, 64'd0, 32'd0}, 1'b1,
      '{64'hffff_ffff, WW_32, ST_OK}},
    '{'{R_ABS32, 64'd0, 64'h1_0000_0000, 64'd0, 32'd0}, 1'b1, '{64'd0, WW_32, ST_OVF}},
    '{'{R_ABS16, 64'd0, 64'hffff_ffff_ffff_8000, 64'd0, 32'd0}, 1'b1,
      '{64'h8000, WW_16, ST_OK}},
    '{'{R_ABS16, 64'd0, 64'h1_0000, 64'd0, 32'd0}, 1'b1, '{64'd0, WW_16, ST_OVF}},
    '{'{R_PREL64, 64'd1, 64'd0, 64'd0, 32'd0}, 1'b1, '{~64'd0, WW_64, ST_OK}},
    '{'{R_MOVW_UABS_G0, 64'd0, 64'h1_2345, 64'd0, 32'd0}, 1'b1,
      '{64'h4_68a0, WW_32, ST_OVF}},
    '{'{R_PREL32, 64'h1000, 64'd0, 64'hffff_ffff_8000_1000, 32'd0}, 1'b0, '0},
    '{'{R_PREL16, ~64'd0, 64'h7fff, 64'd0, ~32'd0}, 1'b0, '0},
    '{'{R_MOVW_UABS_G3, 64'd0, ~64'd0, 64'd0, 32'd0}, 1'b0, '0},
    '{'{R_MOVW_SABS_G0, 64'd0, ~64'd0, 64'd0, ~32'd0}, 1'b0, '0},
    '{'{R_MOVW_SABS_G1, 64'd0, 64'h7fff_ffff, 64'd0, 32'h9280_0000}, 1'b0, '0},
    '{'{R_MOVW_SABS_G2, 64'd0, 64'hffff_8000_0000_0000, 64'd0, 32'hd280_0000}, 1'b0, '0},
    '{'{R_MOVW_PREL_G3, 64'h1000, 64'd0, 64'd0, 32'h9280_0000}, 1'b0, '0},
    '{'{R_LD_PREL_LO19, 64'd0, 64'h10_0000, 64'd0, ~32'd0}, 1'b0, '0},
    '{'{R_ADR_PREL_LO21, 64'h10, 64'h000f_fff0, 64'h1f, 32'h1000_0000}, 1'b0, '0},
    '{'{R_ADR_PREL_PG_HI21, 64'd0, 64'h1_0000_0000, 64'd0, 32'h9000_0000}, 1'b0, '0},
    '{'{R_ADR_GOT_PAGE, ~64'd0, 64'd0, 64'd0, 32'h9000_0000}, 1'b0, '0},
    '{'{R_ADD_ABS_LO12_NC, 64'd0, ~64'd0, 64'd0, 32'd0}, 1'b0, '0},
    '{'{R_LDST128_ABS_LO12_NC, 64'd0, 64'h1234_5678_9abc_def0, 64'd0, 32'h3dc0_0000},
      1'b0, '0},
    '{'{R_TSTBR14, 64'h8000, 64'd0, 64'd0, ~32'd0}, 1'b0, '0},
    '{'{R_CONDBR19, 64'd0, 64'h0fff_fffc, 64'd0, 32'h5400_0000}, 1'b0, '0},
    '{'{R_CALL26, ~64'd0, 64'd0, 64'd0, 32'h9400_0000}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_req = 1'b0;
  logic no_idle = 1'b0;
  int   mismatch_cnt = 0;
  patch_t pending_patches[$];

  a64rel_in_if  reloc_ch ();
  a64rel_out_if patch_ch ();

  aarch64_relocation_patcher u_top (
    .clk   (clk),
    .rst   (rst),
    .reloc (reloc_ch),
    .patch (patch_ch)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned sh);
    return $signed(x) >>> sh;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic void put_data(input logic [63:0] r, input int len,
                                   output logic [63:0] nw, output logic ovf);
    logic [63:0] mask;
    logic [63:0] t;
    if (len == 64) begin
      nw  = r;
      ovf = 1'b0;
    end else begin
      mask = (64'd1 << len) - 64'd1;
      nw   = r & mask;
      t    = sra64(r & ~(mask >> 1), len - 1);
      ovf  = (t + 64'd1) > 64'd2;
    end
  endfunction

  // MOVZ/MOVK immediate; the signed kinds pick MOVZ or MOVN from the shifted sign
  function automatic void put_movw(input logic [63:0] r, input int lsb, input logic sgn,
                                   input logic [31:0] w, output logic [63:0] nw,
                                   output logic ovf);
    logic [63:0] s;
    logic [63:0] hi;
    logic [15:0] imm;
    logic [31:0] word;
    s    = sra64(r, lsb);
    imm  = s[15:0];
    word = w;
    if (sgn) begin
      word[30:29] = s[63] ? 2'b00 : 2'b10;
      if (s[63]) imm = ~imm;
    end
    word[20:5] = imm;
    nw  = {32'd0, word};
    hi  = sra64(s, 16);
    ovf = sgn ? ((hi + 64'd1) > 64'd1) : (hi != 64'd0);
  endfunction

  function automatic void put_imm(input logic [63:0] r, input int lsb, input int len,
                                  input enc_t enc, input logic [31:0] w,
                                  output logic [63:0] nw, output logic ovf);
    logic [63:0] s;
    logic [63:0] mask;
    logic [63:0] f;
    logic [63:0] t;
    logic [31:0] word;
    s    = sra64(r, lsb);
    mask = (64'd1 << len) - 64'd1;
    f    = s & mask;
    word = w;
    case (enc)
      ENC_26: word[25:0]  = f[25:0];
      ENC_19: word[23:5]  = f[18:0];
      ENC_14: word[18:5]  = f[13:0];
      ENC_12: word[21:10] = f[11:0];
      default: begin
        word[30:29] = f[1:0];
        word[23:5]  = f[20:2];
      end
    endcase
    nw  = {32'd0, word};
    t   = sra64(s & ~(mask >> 1), len - 1);
    ovf = (t + 64'd1) >= 64'd2;
  endfunction

  function automatic patch_t predict_patch(input reloc_t x);
    patch_t      p;
    logic [63:0] v;
    logic [63:0] abs_v;
    logic [63:0] prel_v;
    logic [63:0] page_v;
    logic [63:0] nw;
    logic        ovf;
    logic        chk;
    v      = x.sym + x.addend;
    abs_v  = v;
    prel_v = v - x.place;
    page_v = (v & PAGE_MASK) - (x.place & PAGE_MASK);
    nw     = 64'd0;
    ovf    = 1'b0;
    chk    = 1'b1;
    p.width  = WW_32;
    p.status = ST_OK;
    case (x.op)
      R_NULL, R_NONE: begin
        p.width = WW_NONE;
        chk     = 1'b0;
      end
      R_ABS64: begin
        chk     = 1'b0;
        p.width = WW_64;
        put_data(abs_v, 64, nw, ovf);
      end
      R_ABS32: put_data(abs_v, 32, nw, ovf);
      R_ABS16: begin
        p.width = WW_16;
        put_data(abs_v, 16, nw, ovf);
      end
      R_PREL64: begin
        chk     = 1'b0;
        p.width = WW_64;
        put_data(prel_v, 64, nw, ovf);
      end
      R_PREL32: put_data(prel_v, 32, nw, ovf);
      R_PREL16: begin
        p.width = WW_16;
        put_data(prel_v, 16, nw, ovf);
      end
      R_MOVW_UABS_G0, R_MOVW_UABS_G0_NC: begin
        chk = (x.op == R_MOVW_UABS_G0);
        put_movw(abs_v, 0, 1'b0, x.old, nw, ovf);
      end
      R_MOVW_UABS_G1, R_MOVW_UABS_G1_NC: begin
        chk = (x.op == R_MOVW_UABS_G1);
        put_movw(abs_v, 16, 1'b0, x.old, nw, ovf);
      end
      R_MOVW_UABS_G2, R_MOVW_UABS_G2_NC: begin
        chk = (x.op == R_MOVW_UABS_G2);
        put_movw(abs_v, 32, 1'b0, x.old, nw, ovf);
      end
      R_MOVW_UABS_G3: begin
        chk = 1'b0;
        put_movw(abs_v, 48, 1'b0, x.old, nw, ovf);
      end
      R_MOVW_SABS_G0: put_movw(abs_v, 0, 1'b1, x.old, nw, ovf);
      R_MOVW_SABS_G1: put_movw(abs_v, 16, 1'b1, x.old, nw, ovf);
      R_MOVW_SABS_G2: put_movw(abs_v, 32, 1'b1, x.old, nw, ovf);
      R_MOVW_PREL_G0, R_MOVW_PREL_G0_NC: begin
        chk = (x.op == R_MOVW_PREL_G0);
        put_movw(prel_v, 0, chk, x.old, nw, ovf);
      end
      R_MOVW_PREL_G1, R_MOVW_PREL_G1_NC: begin
        chk = (x.op == R_MOVW_PREL_G1);
        put_movw(prel_v, 16, chk, x.old, nw, ovf);
      end
      R_MOVW_PREL_G2, R_MOVW_PREL_G2_NC: begin
        chk = (x.op == R_MOVW_PREL_G2);
        put_movw(prel_v, 32, chk, x.old, nw, ovf);
      end
      R_MOVW_PREL_G3: begin
        chk = 1'b0;
        put_movw(prel_v, 48, 1'b1, x.old, nw, ovf);
      end
      R_LD_PREL_LO19, R_CONDBR19: put_imm(prel_v, 2, 19, ENC_19, x.old, nw, ovf);
      R_ADR_PREL_LO21: put_imm(prel_v, 0, 21, ENC_ADR, x.old, nw, ovf);
      R_ADR_PREL_PG_HI21, R_ADR_PREL_PG_HI21_NC, R_ADR_GOT_PAGE: begin
        chk = (x.op == R_ADR_PREL_PG_HI21);
        put_imm(page_v, 12, 21, ENC_ADR, x.old, nw, ovf);
      end
      R_ADD_ABS_LO12_NC, R_LDST8_ABS_LO12_NC: begin
        chk = 1'b0;
        put_imm(abs_v, 0, 12, ENC_12, x.old, nw, ovf);
      end
      R_LDST16_ABS_LO12_NC: begin
        chk = 1'b0;
        put_imm(abs_v, 1, 11, ENC_12, x.old, nw, ovf);
      end
      R_LDST32_ABS_LO12_NC: begin
        chk = 1'b0;
        put_imm(abs_v, 2, 10, ENC_12, x.old, nw, ovf);
      end
      R_LDST64_ABS_LO12_NC: begin
        chk = 1'b0;
        put_imm(abs_v, 3, 9, ENC_12, x.old, nw, ovf);
      end
      R_LDST128_ABS_LO12_NC: begin
        chk = 1'b0;
        put_imm(abs_v, 4, 8, ENC_12, x.old, nw, ovf);
      end
      R_TSTBR14: put_imm(prel_v, 2, 14, ENC_14, x.old, nw, ovf);
      R_JUMP26, R_CALL26: put_imm(prel_v, 2, 26, ENC_26, x.old, nw, ovf);
      default: begin
        p.width  = WW_NONE;
        p.status = ST_UNSUP;
        chk      = 1'b0;
      end
    endcase
    if (chk && ovf) p.status = ST_OVF;
    p.new_word = nw;
    return p;
  endfunction

  // targets mostly near the place or near zero, so both in-range and overflow cases occur
  function automatic reloc_t random_reloc();
    reloc_t      x;
    logic [63:0] delta;
    logic [63:0] target;
    if ($urandom_range(0, 99) < 6) x.op = OP_W'($urandom_range(0, 4095));
    else x.op = OP_LIST[$urandom_range(0, OP_N - 1)];
    x.place = rnd64();
    delta   = $signed(rnd64()) >>> $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      0: target = delta;
      3: target = rnd64();
      default: target = x.place + delta;
    endcase
    case ($urandom_range(0, 3))
      0: x.addend = 64'd0;
      1: x.addend = $signed(rnd64()) >>> $urandom_range(32, 63);
      default: x.addend = rnd64();
    endcase
    x.sym = target - x.addend;
    x.old = $urandom;
    return x;
  endfunction

  task automatic sender_gap();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < 19) n++;
    if (n > 0) begin
      reloc_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer(input reloc_t x, input patch_t want);
    reloc_ch.valid        <= 1'b1;
    reloc_ch.op           <= x.op;
    reloc_ch.place_addr   <= x.place;
    reloc_ch.symbol_value <= x.sym;
    reloc_ch.addend       <= x.addend;
    reloc_ch.old_word     <= x.old;
    do @(posedge clk); while (!reloc_ch.ready);
    pending_patches.push_back(want);
  endtask

  // sender
  initial begin
    reloc_t x;
    reloc_ch.valid        = 1'b0;
    reloc_ch.op           = '0;
    reloc_ch.place_addr   = '0;
    reloc_ch.symbol_value = '0;
    reloc_ch.addend       = '0;
    reloc_ch.old_word     = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_N; k++) begin
      sender_gap();
      offer(DIR_TAB[k].rq, DIR_TAB[k].typed ? DIR_TAB[k].res : predict_patch(DIR_TAB[k].rq));
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) hold_req = 1'b1;
      no_idle = (i >= 700 && i < 1000);
      if (i == 500) begin
        // drain completely before carrying on
        reloc_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_patches.size() != 0);
      end else if (!no_idle && !hold_req) begin
        sender_gap();
      end
      x = random_reloc();
      offer(x, predict_patch(x));
    end

    reloc_ch.valid <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver
  initial begin
    patch_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        patch_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        patch_ch.ready <= no_idle || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  always @(posedge clk) begin : check_patch
    patch_t want;
    if (!rst && patch_ch.valid && patch_ch.ready) begin
      if (pending_patches.size() == 0) begin
        $error("unexpected result transfer: new_word %h", patch_ch.new_word);
        mismatch_cnt++;
      end else begin
        want = pending_patches.pop_front();
        if (patch_ch.new_word !== want.new_word) begin
          $error("new_word: expected %h, got %h", want.new_word, patch_ch.new_word);
          mismatch_cnt++;
        end
        if (patch_ch.write_width !== want.width) begin
          $error("write_width: expected %0d, got %0d", want.width, patch_ch.write_width);
          mismatch_cnt++;
        end
        if (patch_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, patch_ch.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/a64rel_pkg.sv
sv/a64rel_in_if.sv
sv/a64rel_out_if.sv
sv/a64rel_decode.sv
sv/a64rel_calc.sv
sv/aarch64_relocation_patcher.sv
dv/tb_aarch64_relocation_patcher.sv
